// File: hw/rtl/cpt_pkg.sv
// shared types, widths and constants for the charged particle tracker
// no dependencies; imported by the divider, the multiplier, the core and the bench

package cpt_pkg;

  // port payload widths
  localparam int IN_DATA_W  = 152;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // datapath widths
  localparam int POS_W     = 40;
  localparam int WEIGHT_W  = 24;
  localparam int COUNT_W   = 25;
  localparam int STEPS_W   = 24;
  localparam int GAIN_W    = 32;
  localparam int ROT_W     = 34;
  localparam int WIDE_W    = 48;

  // shared divider: restoring, one quotient bit per cycle
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 36;

  // shared multiplier: b operand taken in two chunks
  localparam int MUL_A_W     = 36;
  localparam int MUL_B_W     = 48;
  localparam int MUL_SPLIT   = 24;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  // detector regions, position units of 2^-32 m
  localparam logic signed [POS_W-1:0] LOST_X   = -40'sd42949672;
  localparam logic signed [POS_W-1:0] LOST_Y   = -40'sd472446402;
  localparam logic signed [POS_W-1:0] HIT_X_LO = 40'sd652835029;
  localparam logic signed [POS_W-1:0] HIT_X_HI = 40'sd2241972928;
  localparam logic signed [POS_W-1:0] HIT_Y_LO = 40'sd429496730;
  localparam logic signed [POS_W-1:0] FAR_X    = 40'sd2671469659;

  typedef enum logic [1:0] {
    OUTC_HIT     = 2'd0,
    OUTC_FAR     = 2'd1,
    OUTC_LOST    = 2'd2,
    OUTC_TIMEOUT = 2'd3
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS      = 3'd0,
    CFG_ROWS      = 3'd1,
    CFG_CELL_W    = 3'd2,
    CFG_CELL_H    = 3'd3,
    CFG_ORG_X     = 3'd4,
    CFG_ORG_Y     = 3'd5,
    CFG_MAX_STEPS = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [MUL_P_W-1:0] acc;
  } mul_rsp_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi_lim;
    logic signed [WIDE_W-1:0] lo_lim;
    hi_lim = WIDE_W'({1'b0, {(POS_W-1){1'b1}}});
    lo_lim = -hi_lim - WIDE_W'(1);
    if (v > hi_lim) begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end else if (v < lo_lim) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return v[POS_W-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/cpt_divider.sv
// shared restoring divider, one quotient bit per clock
// depends on cpt_pkg for widths and request/response structs

module cpt_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  cpt_pkg::div_req_t req,
  output cpt_pkg::div_rsp_t rsp
);
  import cpt_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_NUM_W-1:0] dq_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] dvs_r;

  logic [DIV_DEN_W+1:0] trial;
  logic                 q_bit;
  logic [DIV_DEN_W-1:0] rem_nxt;

  always_comb begin
    trial   = {1'b0, rem_r, dq_r[DIV_NUM_W-1]} - {2'b0, dvs_r};
    q_bit   = !trial[DIV_DEN_W+1];
    rem_nxt = q_bit ? trial[DIV_DEN_W-1:0] : {rem_r[DIV_DEN_W-2:0], dq_r[DIV_NUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dq_r   <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        dq_r  <= {dq_r[DIV_NUM_W-2:0], q_bit};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dq_r;
  assign rsp.rem  = rem_r;

endmodule

// File: hw/rtl/cpt_multiplier.sv
// shared signed multiplier, b operand split in two chunks, low chunk first
// depends on cpt_pkg for widths and request/response structs

module cpt_multiplier (
  input  logic              clk,
  input  logic              rst_n,
  input  cpt_pkg::mul_req_t req,
  output cpt_pkg::mul_rsp_t rsp
);
  import cpt_pkg::*;

  logic                      busy_r;
  logic                      hi_r;
  logic                      done_r;
  logic signed [MUL_A_W-1:0] a_r;
  logic signed [MUL_B_W-1:0] b_r;
  logic signed [MUL_P_W-1:0] acc_r;

  logic signed [MUL_A_W+MUL_SPLIT:0]           p_lo;
  logic signed [MUL_A_W+MUL_B_W-MUL_SPLIT-1:0] p_hi;

  always_comb begin
    p_lo = a_r * $signed({1'b0, b_r[MUL_SPLIT-1:0]});
    p_hi = a_r * $signed(b_r[MUL_B_W-1:MUL_SPLIT]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      hi_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        hi_r   <= 1'b0;
        a_r    <= req.a;
        b_r    <= req.b;
      end else if (busy_r && !hi_r) begin
        acc_r <= MUL_P_W'(p_lo);
        hi_r  <= 1'b1;
      end else if (busy_r) begin
        acc_r  <= acc_r + (MUL_P_W'(p_hi) <<< MUL_SPLIT);
        busy_r <= 1'b0;
        hi_r   <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.acc  = acc_r;

endmodule

// File: hw/rtl/charged_particle_tracker_core.sv
// charged particle tracker: field map store and 2-d boris pusher, one particle at a time
// each step is set by three divisions on the shared divider (cell x, cell y, rotation
// factor s) and nine products on the shared multiplier
// reset (synchronous, active low) clears control and config, the field map itself
// is not cleared
// depends on cpt_pkg, cpt_divider, cpt_multiplier

module charged_particle_tracker_core #(
  parameter int MAP_DEPTH   = 4096,
  parameter int FIELD_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // map_index[11:0], field_value[35:12], step_x[75:36], step_y[115:76],
  // rotation_gain[147:116], zero pad[151:148]
  input  logic [cpt_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type[0]
  input  logic [cpt_pkg::IN_USER_W-1:0]     in_tuser,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // final_x[39:0], final_y[79:40], steps_taken[103:80]
  output logic [cpt_pkg::OUT_DATA_W-1:0]    out_tdata,
  // outcome[1:0]
  output logic [cpt_pkg::OUT_USER_W-1:0]    out_tuser,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [cpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cpt_pkg::*;

  localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int A17 = 17;

  typedef enum logic [4:0] {
    S_IDLE, S_STEP, S_XDIV, S_YDIV, S_READ, S_BL_LO, S_BL_HI, S_BL_B,
    S_GAIN, S_TSQ, S_SDIV, S_VPX, S_VPY, S_VXN, S_VYN, S_MOVE, S_CHECK, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [6:0]               cols_r;
  logic [6:0]               rows_r;
  logic [35:0]              cell_w_r;
  logic [35:0]              cell_h_r;
  logic signed [POS_W-1:0]  org_x_r;
  logic signed [POS_W-1:0]  org_y_r;
  logic [STEPS_W-1:0]       max_steps_r;

  // particle state
  logic signed [POS_W-1:0]  x_r, y_r, vx_r, vy_r;
  logic signed [GAIN_W-1:0] gain_r;
  logic [COUNT_W-1:0]       count_r;

  // per-step working values
  logic                     neg_r;
  logic signed [POS_W:0]    ix_r, iy_r;
  logic [WEIGHT_W-1:0]      wx_r, wy_r;
  logic [2:0]               rd_cnt_r;
  logic                     rd_ok_r;
  logic signed [FIELD_WIDTH-1:0] c_r [4];
  logic signed [FIELD_WIDTH-1:0] lo_r, b_r;
  logic signed [GAIN_W-1:0] t_r;
  logic signed [ROT_W-1:0]  s_r;
  logic signed [WIDE_W-1:0] vpx_r, vxn_r;

  // output register
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [OUT_USER_W-1:0]    out_user_r;

  // shared units
  div_req_t div_req_r;
  div_rsp_t div_rsp;
  mul_req_t mul_req_r;
  mul_rsp_t mul_rsp;

  // field map
  logic [FIELD_WIDTH-1:0]   field_map [MAP_DEPTH];
  logic [FIELD_WIDTH-1:0]   mem_q_r;

  // input field views
  logic [11:0]              in_map_index;
  logic signed [23:0]       in_field_value;
  logic signed [POS_W-1:0]  in_step_x, in_step_y;
  logic signed [GAIN_W-1:0] in_gain;
  logic                     in_req;
  logic signed [31:0]       fv_ext;
  logic [A17-1:0]           wr_idx;
  logic                     map_we;

  // step datapath
  logic [35:0]              cw_eff, ch_eff;
  logic signed [POS_W:0]    rel_x, rel_y;
  logic [POS_W-1:0]         mag_x, mag_y;
  logic [POS_W-1:0]         q0;
  logic [WEIGHT_W-1:0]      q1;
  logic                     rnz;
  logic signed [POS_W:0]    q0_ext;
  logic signed [POS_W:0]    fix_idx;
  logic [WEIGHT_W-1:0]      fix_w;
  logic [WEIGHT_W:0]        w_comp;
  logic [1:0]               corner;
  logic [POS_W+1:0]         cx, cy;
  logic                     in_x, in_y;
  logic [A17-1:0]           rd_addr17;
  logic                     corner_ok;
  logic [AW-1:0]            rd_addr;
  logic signed [FIELD_WIDTH-1:0] blend_base;
  logic signed [35:0]       blend_sum;
  logic signed [FIELD_WIDTH-1:0] blend_val;
  logic signed [GAIN_W-1:0] t_sat;
  logic [33:0]              t2;
  logic [33:0]              denom;
  logic [GAIN_W-1:0]        t_mag;
  logic signed [WIDE_W-1:0] mq;
  logic signed [WIDE_W-1:0] vpy_val;
  logic signed [ROT_W-1:0]  q_s;
  logic signed [ROT_W-1:0]  s_val;
  logic                     region_hit;
  outcome_t                 region_code;

  // ---------------------------------------------------------------------------
  // input unpacking and map write port
  // ---------------------------------------------------------------------------
  always_comb begin
    in_req         = in_tuser[0];
    in_map_index   = in_tdata[11:0];
    in_field_value = $signed(in_tdata[35:12]);
    in_step_x      = $signed(in_tdata[75:36]);
    in_step_y      = $signed(in_tdata[115:76]);
    in_gain        = $signed(in_tdata[147:116]);
    fv_ext         = 32'(in_field_value);
    wr_idx         = {5'b0, in_map_index};
    // a write beyond the map is dropped
    map_we = in_tvalid && in_tready && !in_req && (wr_idx < A17'(MAP_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      field_map[wr_idx[AW-1:0]] <= fv_ext[FIELD_WIDTH-1:0];
    end
    mem_q_r <= field_map[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // cell lookup: offset from the map origin, magnitude for the unsigned divider
  // ---------------------------------------------------------------------------
  always_comb begin
    cw_eff = (cell_w_r == '0) ? 36'd1 : cell_w_r;
    ch_eff = (cell_h_r == '0) ? 36'd1 : cell_h_r;
    rel_x  = (POS_W+1)'(x_r) - (POS_W+1)'(org_x_r);
    rel_y  = (POS_W+1)'(y_r) - (POS_W+1)'(org_y_r);
    mag_x  = rel_x[POS_W] ? POS_W'(-rel_x) : rel_x[POS_W-1:0];
    mag_y  = rel_y[POS_W] ? POS_W'(-rel_y) : rel_y[POS_W-1:0];
  end

  // quotient of |rel|*2^24 / cell: upper part is the cell index, lower part the weight;
  // a negative offset turns the truncated result into a floored one
  always_comb begin
    q0     = div_rsp.quot[DIV_NUM_W-1:WEIGHT_W];
    q1     = div_rsp.quot[WEIGHT_W-1:0];
    rnz    = |div_rsp.rem;
    q0_ext = $signed({1'b0, q0});
    w_comp = {1'b1, {WEIGHT_W{1'b0}}} - {1'b0, q1} - {{WEIGHT_W{1'b0}}, rnz};
    if (!neg_r) begin
      fix_idx = q0_ext;
      fix_w   = q1;
    end else if ((q1 != '0) || rnz) begin
      fix_idx = -q0_ext - (POS_W+1)'(1);
      fix_w   = w_comp[WEIGHT_W-1:0];
    end else begin
      fix_idx = -q0_ext;
      fix_w   = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // corner address and off-grid test for the corner being read
  // ---------------------------------------------------------------------------
  always_comb begin
    corner    = rd_cnt_r[1:0];
    cx        = (POS_W+2)'(ix_r) + {{(POS_W+1){1'b0}}, corner[0]};
    cy        = (POS_W+2)'(iy_r) + {{(POS_W+1){1'b0}}, corner[1]};
    in_x      = !cx[POS_W+1] && (cx < (POS_W+2)'(cols_r));
    in_y      = !cy[POS_W+1] && (cy < (POS_W+2)'(rows_r));
    rd_addr17 = ({10'b0, cy[6:0]} * {10'b0, cols_r}) + {10'b0, cx[6:0]};
    corner_ok = in_x && in_y && (rd_addr17 < A17'(MAP_DEPTH));
    rd_addr   = rd_addr17[AW-1:0];
  end

  // ---------------------------------------------------------------------------
  // blend, rotation factors and velocity products from the shared multiplier
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state_r)
      S_BL_LO: blend_base = c_r[0];
      S_BL_HI: blend_base = c_r[2];
      default: blend_base = lo_r;
    endcase
    blend_sum = 36'(blend_base) + $signed(mul_rsp.acc[59:24]);
    blend_val = blend_sum[FIELD_WIDTH-1:0];

    // t = gain*b/2^16 saturated to q2.30
    if ((mul_rsp.acc[MUL_P_W-1:47] == '0) || (mul_rsp.acc[MUL_P_W-1:47] == '1)) begin
      t_sat = mul_rsp.acc[47:16];
    end else if (mul_rsp.acc[MUL_P_W-1]) begin
      t_sat = {1'b1, {(GAIN_W-1){1'b0}}};
    end else begin
      t_sat = {1'b0, {(GAIN_W-1){1'b1}}};
    end

    t2    = mul_rsp.acc[63:30];
    denom = 34'd1073741824 + t2;
    t_mag = t_r[GAIN_W-1] ? GAIN_W'(-t_r) : t_r;

    mq      = $signed(mul_rsp.acc[77:30]);
    vpy_val = WIDE_W'(vy_r) - mq;

    q_s   = $signed(div_rsp.quot[ROT_W-1:0]);
    s_val = neg_r ? (-q_s - ROT_W'(rnz)) : q_s;
  end

  // ---------------------------------------------------------------------------
  // detector regions, lost checked first
  // ---------------------------------------------------------------------------
  always_comb begin
    region_hit  = 1'b1;
    region_code = OUTC_LOST;
    if ((x_r < LOST_X) || (y_r < LOST_Y)) begin
      region_code = OUTC_LOST;
    end else if ((x_r >= HIT_X_LO) && (x_r <= HIT_X_HI) && (y_r >= HIT_Y_LO)) begin
      region_code = OUTC_HIT;
    end else if (x_r >= FAR_X) begin
      region_code = OUTC_FAR;
    end else begin
      region_hit = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
      mul_req_r.start <= 1'b0;
      cols_r          <= 7'd64;
      rows_r          <= 7'd64;
      cell_w_r        <= 36'd4294967;
      cell_h_r        <= 36'd4294967;
      org_x_r         <= '0;
      org_y_r         <= '0;
      max_steps_r     <= 24'd1048575;
      x_r             <= '0;
      y_r             <= '0;
      vx_r            <= '0;
      vy_r            <= '0;
      count_r         <= '0;
      rd_cnt_r        <= '0;
    end else begin
      div_req_r.start <= 1'b0;
      mul_req_r.start <= 1'b0;
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_COLS:      cols_r      <= cfg_data[6:0];
          CFG_ROWS:      rows_r      <= cfg_data[6:0];
          CFG_CELL_W:    cell_w_r    <= cfg_data[35:0];
          CFG_CELL_H:    cell_h_r    <= cfg_data[35:0];
          CFG_ORG_X:     org_x_r     <= $signed(cfg_data[POS_W-1:0]);
          CFG_ORG_Y:     org_y_r     <= $signed(cfg_data[POS_W-1:0]);
          CFG_MAX_STEPS: max_steps_r <= cfg_data[STEPS_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_req) begin
            x_r     <= '0;
            y_r     <= '0;
            vx_r    <= in_step_x;
            vy_r    <= in_step_y;
            gain_r  <= in_gain;
            count_r <= '0;
            state_r <= S_STEP;
          end
        end

        S_STEP: begin
          div_req_r.start    <= 1'b1;
          div_req_r.dividend <= {mag_x, {WEIGHT_W{1'b0}}};
          div_req_r.divisor  <= cw_eff;
          neg_r              <= rel_x[POS_W];
          state_r            <= S_XDIV;
        end

        S_XDIV: begin
          if (div_rsp.done) begin
            ix_r               <= fix_idx;
            wx_r               <= fix_w;
            div_req_r.start    <= 1'b1;
            div_req_r.dividend <= {mag_y, {WEIGHT_W{1'b0}}};
            div_req_r.divisor  <= ch_eff;
            neg_r              <= rel_y[POS_W];
            state_r            <= S_YDIV;
          end
        end

        S_YDIV: begin
          if (div_rsp.done) begin
            iy_r     <= fix_idx;
            wy_r     <= fix_w;
            rd_cnt_r <= '0;
            state_r  <= S_READ;
          end
        end

        // one corner address per cycle, the read data lands in the following cycle
        S_READ: begin
          rd_ok_r  <= corner_ok;
          rd_cnt_r <= rd_cnt_r + 3'd1;
          if (rd_cnt_r != 3'd0) begin
            c_r[2'(rd_cnt_r - 3'd1)] <= rd_ok_r ? $signed(mem_q_r) : '0;
          end
          if (rd_cnt_r == 3'd4) begin
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= 36'(c_r[1]) - 36'(c_r[0]);
            mul_req_r.b     <= {{(WIDE_W-WEIGHT_W){1'b0}}, wx_r};
            state_r         <= S_BL_LO;
          end
        end

        S_BL_LO: begin
          if (mul_rsp.done) begin
            lo_r            <= blend_val;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= 36'(c_r[3]) - 36'(c_r[2]);
            mul_req_r.b     <= {{(WIDE_W-WEIGHT_W){1'b0}}, wx_r};
            state_r         <= S_BL_HI;
          end
        end

        S_BL_HI: begin
          if (mul_rsp.done) begin
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= 36'(blend_val) - 36'(lo_r);
            mul_req_r.b     <= {{(WIDE_W-WEIGHT_W){1'b0}}, wy_r};
            state_r         <= S_BL_B;
          end
        end

        S_BL_B: begin
          if (mul_rsp.done) begin
            b_r             <= blend_val;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= 36'(gain_r);
            mul_req_r.b     <= WIDE_W'(blend_val);
            state_r         <= S_GAIN;
          end
        end

        S_GAIN: begin
          if (mul_rsp.done) begin
            t_r             <= t_sat;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= 36'(t_sat);
            mul_req_r.b     <= WIDE_W'(t_sat);
            state_r         <= S_TSQ;
          end
        end

        // s = t*2^31 / (2^30 + t*t/2^30), floored
        S_TSQ: begin
          if (mul_rsp.done) begin
            div_req_r.start    <= 1'b1;
            div_req_r.dividend <= {1'b0, t_mag, 31'b0};
            div_req_r.divisor  <= {2'b0, denom};
            neg_r              <= t_r[GAIN_W-1];
            state_r            <= S_SDIV;
          end
        end

        S_SDIV: begin
          if (div_rsp.done) begin
            s_r             <= s_val;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= 36'(t_r);
            mul_req_r.b     <= WIDE_W'(vy_r);
            state_r         <= S_VPX;
          end
        end

        S_VPX: begin
          if (mul_rsp.done) begin
            vpx_r           <= WIDE_W'(vx_r) + mq;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= 36'(t_r);
            mul_req_r.b     <= WIDE_W'(vx_r);
            state_r         <= S_VPY;
          end
        end

        S_VPY: begin
          if (mul_rsp.done) begin
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= 36'(s_r);
            mul_req_r.b     <= vpy_val;
            state_r         <= S_VXN;
          end
        end

        S_VXN: begin
          if (mul_rsp.done) begin
            vxn_r           <= WIDE_W'(vx_r) + mq;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= 36'(s_r);
            mul_req_r.b     <= vpx_r;
            state_r         <= S_VYN;
          end
        end

        S_VYN: begin
          if (mul_rsp.done) begin
            vx_r    <= sat_pos(vxn_r);
            vy_r    <= sat_pos(WIDE_W'(vy_r) - mq);
            state_r <= S_MOVE;
          end
        end

        S_MOVE: begin
          x_r     <= sat_pos(WIDE_W'(x_r) + WIDE_W'(vx_r));
          y_r     <= sat_pos(WIDE_W'(y_r) + WIDE_W'(vy_r));
          count_r <= count_r + COUNT_W'(1);
          state_r <= S_CHECK;
        end

        // region first, then the step limit for the next step
        S_CHECK: begin
          if (region_hit) begin
            out_user_r <= region_code;
            state_r    <= S_DONE;
          end else if (count_r > {1'b0, max_steps_r}) begin
            out_user_r <= OUTC_TIMEOUT;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_STEP;
          end
        end

        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {(count_r[COUNT_W-1] ? {STEPS_W{1'b1}} : count_r[STEPS_W-1:0]),
                            y_r, x_r};
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  cpt_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  cpt_multiplier u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req_r),
    .rsp   (mul_rsp)
  );

endmodule

// File: bench/tb_charged_particle_tracker_core.sv
// self-checking bench for the charged particle tracker core: field map writes and
// boris-pushed particle launches, checked against an in-bench tracer
// depends on cpt_pkg and charged_particle_tracker_core

module tb_charged_particle_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cpt_pkg::*;

  localparam int      DEPTH     = 4096;
  localparam longint  SAT_HI    = (longint'(1) << 39) - 1;
  localparam longint  SAT_LO    = -(longint'(1) << 39);
  localparam longint  CELL_MAX  = (longint'(1) << 36) - 1;
  localparam int      STALL_LIM = 300000;

  typedef struct {
    outcome_t          outcome;
    logic signed [39:0] fx;
    logic signed [39:0] fy;
    logic [23:0]       steps;
  } track_result_t;

  // tracks map contents and register settings, traces each launch and checks results
  class tracker_scoreboard;
    int            field_map[DEPTH];
    longint        cols, rows, cell_w, cell_h, org_x, org_y, step_limit;
    track_result_t pending[$];
    int            errors;
    int            checked;
    int            tally[4];

    function new();
      cols = 64; rows = 64; cell_w = 4294967; cell_h = 4294967;
      org_x = 0; org_y = 0; step_limit = 1048575;
    endfunction

    function void set_reg(cfg_reg_t r, longint v);
      case (r)
        CFG_COLS:      cols = v & 'h7F;
        CFG_ROWS:      rows = v & 'h7F;
        CFG_CELL_W:    cell_w = v & CELL_MAX;
        CFG_CELL_H:    cell_h = v & CELL_MAX;
        CFG_ORG_X:     org_x = longint'($signed(v[39:0]));
        CFG_ORG_Y:     org_y = longint'($signed(v[39:0]));
        CFG_MAX_STEPS: step_limit = v & 'hFFFFFF;
        default: ;
      endcase
    endfunction

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint clamp_pos(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    // floor(v*c/2^30) split so nothing overflows 64 bits
    function longint scale_q30(longint v, longint c);
      longint vh, vl, a, a1, a0;
      vh = fdiv(v, longint'(1) << 20);
      vl = v - vh * (longint'(1) << 20);
      a  = c * vh;
      a1 = fdiv(a, 1024);
      a0 = a - a1 * 1024;
      return a1 + fdiv(a0 * (longint'(1) << 20) + c * vl, longint'(1) << 30);
    endfunction

    function longint map_at(longint ix, longint iy);
      longint addr;
      if (ix < 0 || iy < 0 || ix >= cols || iy >= rows) return 0;
      addr = iy * cols + ix;
      if (addr >= DEPTH) return 0;
      return field_map[addr];
    endfunction

    function longint lerp(longint lo, longint hi, longint w);
      return lo + fdiv(w * (hi - lo), longint'(1) << 24);
    endfunction

    function longint field_at(longint x, longint y);
      longint cw, ch, rx, ry, ix, iy, wx, wy, lo, hi;
      cw = (cell_w == 0) ? 1 : cell_w;
      ch = (cell_h == 0) ? 1 : cell_h;
      rx = x - org_x;
      ry = y - org_y;
      ix = fdiv(rx, cw);
      iy = fdiv(ry, ch);
      wx = ((rx - ix * cw) << 24) / cw;
      wy = ((ry - iy * ch) << 24) / ch;
      lo = lerp(map_at(ix, iy), map_at(ix + 1, iy), wx);
      hi = lerp(map_at(ix, iy + 1), map_at(ix + 1, iy + 1), wx);
      return lerp(lo, hi, wy);
    endfunction

    function track_result_t trace(longint sx, longint sy, longint gain);
      longint px, py, vx, vy, cnt, b, t, t2, s, vpx, vpy;
      int            zone;
      track_result_t r;
      px = 0; py = 0; vx = sx; vy = sy; cnt = 0; zone = 3;
      while (cnt <= step_limit) begin
        b = field_at(px, py);
        t = fdiv(gain * b, 65536);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        t2  = (t * t) >>> 30;
        s   = fdiv(t * (longint'(1) << 31), (longint'(1) << 30) + t2);
        vpx = vx + scale_q30(vy, t);
        vpy = vy - scale_q30(vx, t);
        vx  = clamp_pos(vx + scale_q30(vpy, s));
        vy  = clamp_pos(vy - scale_q30(vpx, s));
        px  = clamp_pos(px + vx);
        py  = clamp_pos(py + vy);
        cnt++;
        if (px < longint'(LOST_X) || py < longint'(LOST_Y)) zone = OUTC_LOST;
        else if (px >= longint'(HIT_X_LO) && px <= longint'(HIT_X_HI) &&
                 py >= longint'(HIT_Y_LO)) zone = OUTC_HIT;
        else if (px >= longint'(FAR_X)) zone = OUTC_FAR;
        else zone = 4;
        if (zone != 4) break;
        zone = 3;
      end
      r.outcome = outcome_t'(zone[1:0]);
      r.fx      = px[39:0];
      r.fy      = py[39:0];
      r.steps   = (cnt > 'hFFFFFF) ? 24'hFFFFFF : cnt[23:0];
      return r;
    endfunction

    function void note_request(bit launch, logic [11:0] idx, logic signed [23:0] fv,
                               logic signed [39:0] sx, logic signed [39:0] sy,
                               logic signed [31:0] gain);
      if (!launch) field_map[idx] = int'(fv);
      else pending.push_back(trace(longint'(sx), longint'(sy), longint'(gain)));
    endfunction

    function void check_result(track_result_t got);
      track_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: outcome %0d x %0d y %0d steps %0d",
                                   got.outcome, got.fx, got.fy, got.steps);
        return;
      end
      want = pending.pop_front();
      checked++;
      tally[want.outcome]++;
      if (got.outcome !== want.outcome || got.fx !== want.fx || got.fy !== want.fy ||
          got.steps !== want.steps) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch on launch %0d: expected outcome %0d x %0d y %0d steps %0d",
                   checked, want.outcome, want.fx, want.fy, want.steps);
          $display("                     actual   outcome %0d x %0d y %0d steps %0d",
                   got.outcome, got.fx, got.fy, got.steps);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tracker_scoreboard sb;
  bit                idling;    // random gaps on both sides while set
  int                stall_left;
  int                quiet_cycles;

  charged_particle_tracker_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check every accepted result, stall in random bursts
  always @(posedge clk) begin
    track_result_t got;
    if (out_tvalid && out_tready) begin
      got.outcome = outcome_t'(out_tuser);
      got.fx      = out_tdata[39:0];
      got.fy      = out_tdata[79:40];
      got.steps   = out_tdata[103:80];
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog: cycles without any handshake on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIM);
      $display("FAIL");
      $finish;
    end
  end

  // one request, with an optional idle burst ahead of it
  task automatic send_request(bit launch, logic [11:0] idx, logic signed [23:0] fv,
                              logic signed [39:0] sx, logic signed [39:0] sy,
                              logic signed [31:0] gain);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= launch;
    in_tdata  <= {4'b0, gain, sy, sx, fv, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_request(launch, idx, fv, sx, sy, gain);
  endtask

  task automatic launch(longint sx, longint sy, longint gain);
    send_request(1'b1, 12'($urandom), 24'($urandom), sx[39:0], sy[39:0], gain[31:0]);
  endtask

  task automatic map_write(int idx, int fv);
    send_request(1'b0, idx[11:0], fv[23:0], {$urandom, $urandom}, {$urandom, $urandom},
                 $urandom);
  endtask

  // drain results, let a trailing map write settle, then write all registers
  task automatic program_regs(longint cols, longint rows, longint cw, longint ch,
                              longint ox, longint oy, longint steps);
    longint   vals[7];
    cfg_reg_t order[7];
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    vals  = '{cols, rows, cw, ch, ox, oy, steps};
    order = '{CFG_COLS, CFG_ROWS, CFG_CELL_W, CFG_CELL_H, CFG_ORG_X, CFG_ORG_Y,
              CFG_MAX_STEPS};
    foreach (order[k]) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= vals[k][39:0];
      @(posedge clk);
      sb.set_reg(order[k], vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic longint rand_span(longint lo, longint hi);
    longint r;
    r = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF);
    return lo + r % (hi - lo + 1);
  endfunction

  // mostly gentle, well-formed flights through the map; some map rewrites and noise
  task automatic random_phase(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) map_write($urandom_range(0, DEPTH - 1), $urandom);
      else if (pick < 88)
        launch(rand_span(longint'(1) << 26, longint'(1) << 29),
               rand_span(-(longint'(1) << 28), longint'(1) << 28),
               rand_span(-(longint'(1) << 22), longint'(1) << 22));
      else
        launch(rand_span(SAT_LO, SAT_HI), rand_span(SAT_LO, SAT_HI),
               longint'($signed($urandom)));
    end
  endtask

  task automatic random_regs();
    longint ox, oy;
    ox = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? SAT_HI : SAT_LO)
                                     : rand_span(-(longint'(1) << 30), longint'(1) << 30);
    oy = rand_span(-(longint'(1) << 30), longint'(1) << 30);
    program_regs($urandom_range(1, 64), $urandom_range(1, 64),
                 rand_span(longint'(1) << 24, longint'(1) << 27),
                 rand_span(longint'(1) << 24, longint'(1) << 27),
                 ox, oy, $urandom_range(1, 24));
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_COLS;
    cfg_data     = '0;
    idling       = 1'b1;
    stall_left   = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // the map is not cleared by reset, so fill every entry before any launch
    for (int a = 0; a < DEPTH; a++) map_write(a, $urandom);

    // reset settings, huge step limit: straight flights that end on the first step
    map_write(0, -8388608);
    map_write(DEPTH - 1, 8388607);
    launch(SAT_HI, 0, 0);                       // saturates on the far side
    launch(SAT_LO, 0, 0);                       // lost to the left
    launch(0, SAT_LO, 0);                       // lost below
    launch(1700000000, 1000000000, 0);          // into the upper detector
    launch(-42949673, 0, 0);                    // just past the left edge

    // single cell, widest spacing, step limit of one: timeouts and rotation overflow
    program_regs(1, 1, CELL_MAX, CELL_MAX, 0, 0, 1);
    launch(0, 0, 64'sh7FFF_FFFF);
    launch(1000, -1000, -64'sh8000_0000);
    launch(5000000, 3000000, 64'sh7FFF_FFFF);
    launch(-7, 9, 1 << 30);

    // full grid, unit cells, far origins: everything reads as off the map
    program_regs(64, 64, 1, 1, SAT_LO, SAT_LO, 'hFFFFFF);
    launch(SAT_HI, 12345, longint'($signed($urandom)));
    launch(1000000000, -600000000, -64'sh8000_0000);
    program_regs(64, 64, 1, 1, SAT_HI, SAT_HI, 'hFFFFFF);
    launch(3000000000, 0, 64'sh7FFF_FFFF);

    repeat (4) begin
      random_regs();
      random_phase(18);
    end
    // last stretch runs with no gaps on either side
    random_regs();
    idling = 1'b0;
    random_phase(18);
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("checked %0d launches: %0d hit, %0d far side, %0d lost, %0d timed out",
             sb.checked, sb.tally[OUTC_HIT], sb.tally[OUTC_FAR], sb.tally[OUTC_LOST],
             sb.tally[OUTC_TIMEOUT]);
    $display("map fully written first, seven register settings including the extremes");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_divider.sv
hw/rtl/cpt_multiplier.sv
hw/rtl/charged_particle_tracker_core.sv
bench/tb_charged_particle_tracker_core.sv
